// ===== sv/gcode_move_line_parser_defines.svh =====
// Assertion macros shared by the G-code move line parser RTL.
`ifndef GCODE_MOVE_LINE_PARSER_DEFINES_SVH
`define GCODE_MOVE_LINE_PARSER_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define GMLP_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("gmlp assertion failed");

// Next-cycle implication, sampled on i_clk, off during reset.
`define GMLP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("gmlp assertion failed");

`endif

// ===== sv/gmlp_pkg.sv =====
// Types, character codes and constants for the G-code move line parser.
`timescale 1ns / 1ps

package gmlp_pkg;

    localparam logic [3:0] ARG_CHARS = 4'd9;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_G     = 8'h47;
    localparam logic [7:0] CH_X     = 8'h58;
    localparam logic [7:0] CH_Y     = 8'h59;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    typedef enum logic [2:0] {
        PH_CMD      = 3'd0,
        PH_NUM      = 3'd1,
        PH_DONE_CMD = 3'd2,
        PH_WAIT_ARG = 3'd3,
        PH_ARG      = 3'd4,
        PH_SKIP     = 3'd5
    } t_phase;

    typedef enum logic [2:0] {
        NP_SIGN  = 3'd0,
        NP_INT   = 3'd1,
        NP_FRAC1 = 3'd2,
        NP_FRAC2 = 3'd3,
        NP_STOP  = 3'd4
    } t_nphase;

    typedef enum logic [1:0] {
        AX_NONE = 2'd0,
        AX_X    = 2'd1,
        AX_Y    = 2'd2
    } t_axis;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_REJECT = 2'd1,
        ST_EARLY  = 2'd2
    } t_status;

    typedef struct packed {
        logic [31:0] acc;
        logic [3:0]  tenths;
        t_nphase     phase;
        logic        neg;
    } t_num;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic        x_given;
        logic        y_given;
        t_status     status;
    } t_result;

    function automatic logic is_term(input logic [7:0] c);
        return (c == CH_SEMI) || (c == CH_NUL);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // acc * 10 + d, saturated to 32 bits
    function automatic logic [31:0] mac10_sat(input logic [31:0] acc, input logic [3:0] d);
        logic [35:0] m;
        m = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + {32'd0, d};
        return (|m[35:32]) ? 32'hFFFF_FFFF : m[31:0];
    endfunction

endpackage

// ===== sv/gmlp_num.sv =====
// Decimal number step: next accumulator state for one character, and tenths value.
`timescale 1ns / 1ps

module gmlp_num (
    input  gmlp_pkg::t_num  i_num,
    input  logic [7:0]      i_char,
    output gmlp_pkg::t_num  o_num,
    output logic [31:0]     o_tenths
);

    logic               w_dig;
    logic [3:0]         w_dval;
    gmlp_pkg::t_nphase  w_phase;

    assign w_dig  = gmlp_pkg::is_digit(i_char);
    assign w_dval = 4'(i_char - gmlp_pkg::CH_ZERO);

    assign o_tenths = i_num.neg ? 32'd0 : gmlp_pkg::mac10_sat(i_num.acc, i_num.tenths);

    always_comb begin
        o_num   = i_num;
        w_phase = i_num.phase;
        if (i_num.phase == gmlp_pkg::NP_SIGN) begin
            w_phase = gmlp_pkg::NP_INT;
        end
        if (i_num.phase == gmlp_pkg::NP_SIGN &&
            i_char >= gmlp_pkg::CH_TAB && i_char <= gmlp_pkg::CH_CR) begin
            o_num.phase = gmlp_pkg::NP_SIGN;
        end else if (i_num.phase == gmlp_pkg::NP_SIGN && i_char == gmlp_pkg::CH_MINUS) begin
            o_num.neg   = 1'b1;
            o_num.phase = gmlp_pkg::NP_INT;
        end else if (i_num.phase == gmlp_pkg::NP_SIGN && i_char == gmlp_pkg::CH_PLUS) begin
            o_num.phase = gmlp_pkg::NP_INT;
        end else begin
            unique case (w_phase)
                gmlp_pkg::NP_INT: begin
                    o_num.phase = gmlp_pkg::NP_INT;
                    if (w_dig) begin
                        o_num.acc = gmlp_pkg::mac10_sat(i_num.acc, w_dval);
                    end else if (i_char == gmlp_pkg::CH_DOT) begin
                        o_num.phase = gmlp_pkg::NP_FRAC1;
                    end else begin
                        o_num.phase = gmlp_pkg::NP_STOP;
                    end
                end
                gmlp_pkg::NP_FRAC1: begin
                    if (w_dig) begin
                        o_num.tenths = w_dval;
                        o_num.phase  = gmlp_pkg::NP_FRAC2;
                    end else begin
                        o_num.phase = gmlp_pkg::NP_STOP;
                    end
                end
                gmlp_pkg::NP_FRAC2: begin
                    if (!w_dig) begin
                        o_num.phase = gmlp_pkg::NP_STOP;
                    end
                end
                default: begin
                    o_num.phase = w_phase;
                end
            endcase
        end
    end

endmodule

// ===== sv/gmlp_core.sv =====
// Line parser state: command recognition, argument tracking and line result.
`timescale 1ns / 1ps

module gmlp_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic [7:0]          i_char,
    output gmlp_pkg::t_result   o_res
);

    gmlp_pkg::t_phase   r_phase, n_phase;
    logic               r_rej, n_rej;
    gmlp_pkg::t_axis    r_axis, n_axis;
    logic [3:0]         r_cnt, n_cnt;
    gmlp_pkg::t_num     r_num, n_num;
    logic [31:0]        r_x, n_x, r_y, n_y;
    logic               r_xf, n_xf, r_yf, n_yf;

    gmlp_pkg::t_num     w_fed;
    logic [31:0]        w_val;
    logic [31:0]        w_ax, w_ay;
    logic               w_axf, w_ayf;
    logic [31:0]        w_fx, w_fy;
    logic               w_fxf, w_fyf;
    gmlp_pkg::t_status  w_status;
    gmlp_pkg::t_num     w_clr;

    gmlp_num u_num (
        .i_num    (r_num),
        .i_char   (i_char),
        .o_num    (w_fed),
        .o_tenths (w_val)
    );

    assign w_clr = '{acc: 32'd0, tenths: 4'd0, phase: gmlp_pkg::NP_SIGN, neg: 1'b0};

    // pending axis applied
    always_comb begin
        w_ax  = r_x;
        w_ay  = r_y;
        w_axf = r_xf;
        w_ayf = r_yf;
        if (r_axis == gmlp_pkg::AX_X) begin
            w_ax  = w_val;
            w_axf = 1'b1;
        end else if (r_axis == gmlp_pkg::AX_Y) begin
            w_ay  = w_val;
            w_ayf = 1'b1;
        end
    end

    // terminator result
    always_comb begin
        w_fx  = r_x;
        w_fy  = r_y;
        w_fxf = r_xf;
        w_fyf = r_yf;
        if (i_char == gmlp_pkg::CH_SEMI || r_phase == gmlp_pkg::PH_ARG) begin
            w_fx  = w_ax;
            w_fy  = w_ay;
            w_fxf = w_axf;
            w_fyf = w_ayf;
        end
        if (r_rej) begin
            w_status = gmlp_pkg::ST_REJECT;
        end else if (r_phase == gmlp_pkg::PH_CMD || r_phase == gmlp_pkg::PH_NUM) begin
            w_status = gmlp_pkg::ST_EARLY;
        end else begin
            w_status = gmlp_pkg::ST_OK;
        end
        o_res.status  = w_status;
        o_res.x_given = (w_status == gmlp_pkg::ST_OK) && w_fxf;
        o_res.y_given = (w_status == gmlp_pkg::ST_OK) && w_fyf;
        o_res.x       = o_res.x_given ? w_fx : 32'd0;
        o_res.y       = o_res.y_given ? w_fy : 32'd0;
    end

    always_comb begin
        n_phase = r_phase;
        n_rej   = r_rej;
        n_axis  = r_axis;
        n_cnt   = r_cnt;
        n_num   = r_num;
        n_x     = r_x;
        n_y     = r_y;
        n_xf    = r_xf;
        n_yf    = r_yf;
        if (gmlp_pkg::is_term(i_char)) begin
            n_phase = gmlp_pkg::PH_CMD;
            n_rej   = 1'b0;
            n_axis  = gmlp_pkg::AX_NONE;
            n_cnt   = 4'd0;
            n_num   = w_clr;
            n_x     = 32'd0;
            n_y     = 32'd0;
            n_xf    = 1'b0;
            n_yf    = 1'b0;
        end else if (!r_rej) begin
            unique case (r_phase)
                gmlp_pkg::PH_CMD: begin
                    if (i_char == gmlp_pkg::CH_G) begin
                        n_phase = gmlp_pkg::PH_NUM;
                    end else if (i_char != gmlp_pkg::CH_SPACE) begin
                        n_rej = 1'b1;
                    end
                end
                gmlp_pkg::PH_NUM: begin
                    if (i_char == gmlp_pkg::CH_ONE) begin
                        n_phase = gmlp_pkg::PH_DONE_CMD;
                    end else if (i_char != gmlp_pkg::CH_ZERO) begin
                        n_rej = 1'b1;
                    end
                end
                gmlp_pkg::PH_DONE_CMD: begin
                    if (i_char == gmlp_pkg::CH_SPACE) begin
                        n_phase = gmlp_pkg::PH_WAIT_ARG;
                    end else begin
                        n_rej = 1'b1;
                    end
                end
                gmlp_pkg::PH_WAIT_ARG: begin
                    if (i_char == gmlp_pkg::CH_X || i_char == gmlp_pkg::CH_Y) begin
                        n_axis  = (i_char == gmlp_pkg::CH_X) ? gmlp_pkg::AX_X
                                                             : gmlp_pkg::AX_Y;
                        n_cnt   = 4'd0;
                        n_num   = w_clr;
                        n_phase = gmlp_pkg::PH_ARG;
                    end else if (i_char != gmlp_pkg::CH_SPACE) begin
                        n_phase = gmlp_pkg::PH_SKIP;
                    end
                end
                gmlp_pkg::PH_ARG: begin
                    if (i_char == gmlp_pkg::CH_SPACE) begin
                        n_x     = w_ax;
                        n_y     = w_ay;
                        n_xf    = w_axf;
                        n_yf    = w_ayf;
                        n_axis  = gmlp_pkg::AX_NONE;
                        n_phase = gmlp_pkg::PH_WAIT_ARG;
                    end else if (r_cnt >= gmlp_pkg::ARG_CHARS) begin
                        n_phase = gmlp_pkg::PH_SKIP;
                    end else begin
                        n_cnt = 4'(r_cnt + 4'd1);
                        n_num = w_fed;
                    end
                end
                gmlp_pkg::PH_SKIP: begin
                    if (i_char == gmlp_pkg::CH_SPACE) begin
                        n_phase = gmlp_pkg::PH_WAIT_ARG;
                    end
                end
                default: begin
                    n_phase = gmlp_pkg::PH_CMD;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= gmlp_pkg::PH_CMD;
            r_rej   <= 1'b0;
            r_axis  <= gmlp_pkg::AX_NONE;
            r_cnt   <= 4'd0;
            r_num   <= '{acc: 32'd0, tenths: 4'd0, phase: gmlp_pkg::NP_SIGN, neg: 1'b0};
            r_x     <= 32'd0;
            r_y     <= 32'd0;
            r_xf    <= 1'b0;
            r_yf    <= 1'b0;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_rej   <= n_rej;
            r_axis  <= n_axis;
            r_cnt   <= n_cnt;
            r_num   <= n_num;
            r_x     <= n_x;
            r_y     <= n_y;
            r_xf    <= n_xf;
            r_yf    <= n_yf;
        end
    end

endmodule

// ===== sv/gcode_move_line_parser.sv =====
// Top level of the G-code linear move line parser: input word register, parser, result register.
//
// Usage:
//   Input channel: one character per word on i_char_code, taken when i_valid is
//   high and o_stall is low. ';' or NUL ends a line.
//   Output channel: one result word per line end on o_x_tenths_mm, o_y_tenths_mm,
//   o_x_given, o_y_given, o_line_status, taken when o_valid is high and i_stall low.
//   A terminator is held in the input register, then the parser update writes
//   its result into the result register.
//   Throughput: one character per cycle while o_stall is low; the parser
//   state is updated once per character by a single multiply-by-ten accumulate.
//   Stalls: characters that end no line keep flowing while a result waits; a
//   terminator waits in the input register until the result register is free,
//   and o_stall is raised meanwhile.
//   Reset (i_rst_n low, synchronous): both registers empty, parser back to
//   awaiting the command letter with no axes pending.
`timescale 1ns / 1ps
`include "gcode_move_line_parser_defines.svh"

module gcode_move_line_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_char_code,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_x_tenths_mm,
    output logic [31:0] o_y_tenths_mm,
    output logic        o_x_given,
    output logic        o_y_given,
    output logic [1:0]  o_line_status
);

    logic               r_in_valid;
    logic [7:0]         r_in_char;
    logic               r_out_valid;
    gmlp_pkg::t_result  r_out;

    logic               w_term;
    logic               w_out_free;
    logic               w_consume;
    logic               w_accept;
    gmlp_pkg::t_result  w_res;

    assign w_term     = gmlp_pkg::is_term(r_in_char);
    assign w_out_free = !r_out_valid || !i_stall;
    assign w_consume  = r_in_valid && (!w_term || w_out_free);
    assign o_stall    = r_in_valid && !w_consume;
    assign w_accept   = i_valid && !o_stall;

    gmlp_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_consume),
        .i_char  (r_in_char),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_in_valid <= 1'b1;
                r_in_char  <= i_char_code;
            end else if (w_consume) begin
                r_in_valid <= 1'b0;
            end
            if (w_consume && w_term) begin
                r_out_valid <= 1'b1;
                r_out       <= w_res;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_x_tenths_mm = r_out.x;
    assign o_y_tenths_mm = r_out.y;
    assign o_x_given     = r_out.x_given;
    assign o_y_given     = r_out.y_given;
    assign o_line_status = r_out.status;

    `GMLP_ASSERT_NEXT(a_term_gives_result, w_consume && w_term, r_out_valid)
    `GMLP_ASSERT_IMPL(a_stall_needs_word, o_stall, r_in_valid && w_term && r_out_valid)
    `GMLP_ASSERT_IMPL(a_bad_line_no_axes,
        r_out_valid && (r_out.status != gmlp_pkg::ST_OK), !r_out.x_given && !r_out.y_given)
    `GMLP_ASSERT_IMPL(a_absent_axis_zero,
        r_out_valid && !r_out.x_given, r_out.x == 32'd0)

endmodule
